// ===== src/wildcard_byte_pattern_search_core_assert.svh =====
// Assertion macros for the wildcard byte pattern search core.
// Used by the top level; depends on nothing else.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define WBPS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define WBPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/wbps_pkg.sv =====
// Shared constants and types for the wildcard byte pattern search core.
// No dependencies; used by the channel interfaces and the top level.
package wbps_pkg;

    localparam int DATA_W          = 8;
    localparam int OFFSET_W        = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int LEN_CFG_W       = 6;
    localparam int NUM_PAT_WORDS   = 4;
    localparam int PAT_WORD_IDX_W  = 2;
    localparam int BYTES_PER_WORD  = CFG_DATA_W / DATA_W;
    localparam int PAT_BYTES       = NUM_PAT_WORDS * BYTES_PER_WORD;
    localparam int PAT_BYTE_IDX_W  = $clog2(PAT_BYTES);
    localparam int PATTERN_MAX_DEF = 32;

    typedef logic [DATA_W-1:0]    t_byte;
    typedef logic [OFFSET_W-1:0]  t_offset;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx REG_PAT_WORD_0 = 3'd0;
    localparam t_cfg_idx REG_PAT_WORD_1 = 3'd1;
    localparam t_cfg_idx REG_PAT_WORD_2 = 3'd2;
    localparam t_cfg_idx REG_PAT_WORD_3 = 3'd3;
    localparam t_cfg_idx REG_WILDCARD   = 3'd4;
    localparam t_cfg_idx REG_PAT_LEN    = 3'd5;

    localparam logic [LEN_CFG_W-1:0] PAT_LEN_RESET = 6'd1;

endpackage

// ===== src/wbps_in_if.sv =====
// Input channel of the pattern search core: one region byte per word.
// Depends on wbps_pkg.
interface wbps_in_if;
    logic                  valid;
    logic                  ready;
    wbps_pkg::t_byte       data_byte;
    logic                  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/wbps_out_if.sv =====
// Result channel of the pattern search core: found flag and match offset.
// Depends on wbps_pkg.
interface wbps_out_if;
    logic                  valid;
    logic                  ready;
    logic                  found;
    wbps_pkg::t_offset     match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ===== src/wildcard_byte_pattern_search_core.sv =====
// Top level of the wildcard byte pattern search core.
// Depends on wbps_pkg, wbps_in_if, wbps_out_if and the assertion macro header.
//
// Usage:
//   i_in carries the bytes of a region, one word per byte, last_byte set on the
//   region's final byte. o_out carries at most one word per region: found=1 with
//   the start offset of the first match, or found=0 (offset 0) on the last byte
//   when nothing matched. Bytes after a match give no word; the last byte still
//   closes the region and the next byte starts a new one at offset 0.
//   Configuration (pattern words, wildcard value, pattern length) is written
//   through i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle; indexes past
//   the pattern length register are ignored.
// Timing:
//   A byte accepted from i_in lands in the window register; from there its result
//   is loaded into the output register. One byte per cycle is sustained while the
//   receiver does not stall: the window compare is a single stage of parallel byte
//   compares against a pattern that is pre-aligned to the length after writes.
// Reset (synchronous, active low) empties both stages, restores the default
// configuration and starts a fresh region. When the receiver stalls, the result
// word holds; the window stage holds only while its byte owes a result, and
// then input ready drops.
module wildcard_byte_pattern_search_core #(
    parameter int PatternMax = wbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  wbps_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wbps_in_if.sink                         i_in,
    wbps_out_if.source                      o_out
);

`include "wildcard_byte_pattern_search_core_assert.svh"

    localparam int LenW = $clog2(PatternMax + 1);

    // Configuration registers.
    logic [wbps_pkg::CFG_DATA_W-1:0] r_pat [wbps_pkg::NUM_PAT_WORDS];
    wbps_pkg::t_byte                 r_wildcard;
    logic [wbps_pkg::LEN_CFG_W-1:0]  r_pat_len;

    // Pattern aligned to the window: lane k compares against the byte k places
    // back from the newest, with a care bit that drops wildcards and unused lanes.
    wbps_pkg::t_byte w_pat_bytes [wbps_pkg::PAT_BYTES];
    wbps_pkg::t_byte n_q    [PatternMax];
    wbps_pkg::t_byte r_q    [PatternMax];
    logic [PatternMax-1:0]   n_care;
    logic [PatternMax-1:0]   r_care;
    logic [LenW-1:0]         n_len_eff;
    logic [LenW-1:0]         r_len_eff;

    // Window stage.
    logic                    r_s1_valid;
    logic                    r_s1_last;
    wbps_pkg::t_byte         r_win [PatternMax];
    wbps_pkg::t_offset       r_seen;
    logic                    r_region_end;
    logic                    r_reported;

    // Output stage.
    logic                    r_out_valid;
    logic                    r_out_found;
    wbps_pkg::t_offset       r_out_offset;

    logic [PatternMax-1:0]   w_lane_ok;
    logic                    w_len_zero;
    logic                    w_match;
    logic                    w_hit;
    logic                    w_has_res;
    logic                    w_s1_adv;
    logic                    w_load_out;
    logic                    w_in_acc;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < wbps_pkg::NUM_PAT_WORDS; w++) begin
                r_pat[w] <= '0;
            end
            r_wildcard <= '0;
            r_pat_len  <= wbps_pkg::PAT_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                wbps_pkg::REG_PAT_WORD_0, wbps_pkg::REG_PAT_WORD_1,
                wbps_pkg::REG_PAT_WORD_2, wbps_pkg::REG_PAT_WORD_3: begin
                    r_pat[i_cfg_idx[wbps_pkg::PAT_WORD_IDX_W-1:0]] <= i_cfg_data;
                end
                wbps_pkg::REG_WILDCARD: begin
                    r_wildcard <= i_cfg_data[wbps_pkg::DATA_W-1:0];
                end
                wbps_pkg::REG_PAT_LEN: begin
                    r_pat_len <= i_cfg_data[wbps_pkg::LEN_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar j = 0; j < wbps_pkg::PAT_BYTES; j++) begin : g_pat_bytes
        assign w_pat_bytes[j] =
            r_pat[j / wbps_pkg::BYTES_PER_WORD][(j % wbps_pkg::BYTES_PER_WORD) * 8 +: 8];
    end

    always_comb begin
        int idx;
        idx = 0;
        if (32'(r_pat_len) > 32'(PatternMax)) begin
            n_len_eff = LenW'(PatternMax);
        end else begin
            n_len_eff = LenW'(r_pat_len);
        end
        for (int k = 0; k < PatternMax; k++) begin
            n_q[k]    = '0;
            n_care[k] = 1'b0;
            if (k < int'(n_len_eff)) begin
                idx = int'(n_len_eff) - 1 - k;
                // Pattern bytes past the configured words read as zero.
                if (idx < wbps_pkg::PAT_BYTES) begin
                    n_q[k] = w_pat_bytes[wbps_pkg::PAT_BYTE_IDX_W'(idx)];
                end
                n_care[k] = (n_q[k] != r_wildcard);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_care    <= n_care;
        r_len_eff <= n_len_eff;
    end

    // ---------------- window stage ----------------
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = !r_s1_valid || w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_win[0] <= i_in.data_byte;
            for (int i = 1; i < PatternMax; i++) begin
                r_win[i] <= r_win[i-1];
            end
            r_s1_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_region_end <= 1'b1;
            r_seen       <= '0;
            r_reported   <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid   <= 1'b1;
                r_region_end <= i_in.last_byte;
                r_seen       <= (r_region_end ? '0 : r_seen) + wbps_pkg::t_offset'(1);
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_reported <= r_s1_last ? 1'b0 : (r_reported || w_hit);
            end
        end
    end

    // ---------------- compare and result ----------------
    for (genvar k = 0; k < PatternMax; k++) begin : g_lanes
        assign w_lane_ok[k] = !r_care[k] || (r_q[k] == r_win[k]);
    end

    assign w_len_zero = (r_len_eff == '0);
    // Positions before the window has filled (also just after a count wrap)
    // are not checked.
    assign w_match    = (&w_lane_ok) && (r_seen >= wbps_pkg::t_offset'(r_len_eff));
    assign w_hit      = !r_reported && (w_len_zero || w_match);
    assign w_has_res  = !r_reported && (w_len_zero || w_match || r_s1_last);
    assign w_s1_adv   = r_s1_valid && (!w_has_res || !r_out_valid || o_out.ready);
    assign w_load_out = w_s1_adv && w_has_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_found  <= w_hit;
            r_out_offset <= (w_hit && !w_len_zero) ?
                            (r_seen - wbps_pkg::t_offset'(r_len_eff)) : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_found;
    assign o_out.match_offset = r_out_offset;

    // ---------------- assertions ----------------
    `WBPS_ASSERT_IMPLY(a_no_result_after_report, i_clk, i_rst_n,
        r_s1_valid && r_reported, !w_load_out,
        "result produced after a match was already reported")
    `WBPS_ASSERT_IMPLY(a_out_not_overwritten, i_clk, i_rst_n,
        r_out_valid && !o_out.ready, !w_load_out,
        "pending result overwritten")
    `WBPS_ASSERT_IMPLY(a_s1_not_overwritten, i_clk, i_rst_n,
        w_in_acc && r_s1_valid, w_s1_adv,
        "window stage overwritten while holding a byte")
    `WBPS_ASSERT_IMPLY(a_not_found_on_last, i_clk, i_rst_n,
        w_load_out && !w_hit, r_s1_last,
        "not-found result on a byte that does not end the region")

endmodule

// ===== tb/sv/wildcard_byte_pattern_search_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for wildcard_byte_pattern_search_core: streams directed and random regions
// through the byte channel and checks every result word against a predictor.
// Depends on wbps_pkg, wbps_in_if, wbps_out_if and the core itself.
module wildcard_byte_pattern_search_core_tb;

    localparam int WINDOW_DEPTH   = wbps_pkg::PATTERN_MAX_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TARGET_BYTES   = 1650;
    localparam wbps_pkg::t_cfg_idx REG_SPARE_6 = wbps_pkg::REG_PAT_LEN + 3'd1;
    localparam wbps_pkg::t_cfg_idx REG_SPARE_7 = wbps_pkg::REG_PAT_LEN + 3'd2;

    typedef struct packed {
        wbps_pkg::t_byte data;
        logic            is_last;
    } t_region_byte;

    typedef struct packed {
        logic              found;
        wbps_pkg::t_offset offset;
    } t_scan_result;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THREE_OF_FOUR, RX_SPARSE} t_rx_mode;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    wbps_pkg::t_cfg_idx              i_cfg_idx;
    logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data;

    wbps_in_if  byte_ch();
    wbps_out_if result_ch();

    wildcard_byte_pattern_search_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (byte_ch),
        .o_out      (result_ch)
    );

    // Predictor copy of the configuration and the scan state.
    logic [wbps_pkg::CFG_DATA_W-1:0] pat_words [wbps_pkg::NUM_PAT_WORDS];
    wbps_pkg::t_byte                 wild_value;
    logic [wbps_pkg::LEN_CFG_W-1:0]  pat_len;
    wbps_pkg::t_byte                 window_bytes [WINDOW_DEPTH];
    wbps_pkg::t_offset               bytes_seen;
    logic                            region_done;

    t_region_byte byte_queue [$];
    t_scan_result results_due [$];
    int           error_count  = 0;
    int           bytes_queued = 0;

    int       burst_left   = 0;
    int       gap_left     = 0;
    int       hold_left    = 0;
    int       rx_mode_left = 0;
    logic     long_hold_req;
    t_rx_mode rx_mode      = RX_OPEN;
    logic [1:0] rx_tick    = '0;
    int       quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic wbps_pkg::t_byte pattern_byte(int unsigned j);
        if (j >= wbps_pkg::PAT_BYTES)
            return '0;
        return pat_words[j / wbps_pkg::BYTES_PER_WORD]
                        [(j % wbps_pkg::BYTES_PER_WORD) * wbps_pkg::DATA_W +: wbps_pkg::DATA_W];
    endfunction

    function automatic int unsigned active_length();
        return (pat_len > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(pat_len);
    endfunction

    function automatic void clear_window();
        int i;
        for (i = 0; i < WINDOW_DEPTH; i++)
            window_bytes[i] = '0;
        bytes_seen  = '0;
        region_done = 1'b0;
    endfunction

    // Shifts one region byte into the window and queues the result it causes, if any.
    function automatic void scan_byte(wbps_pkg::t_byte data, logic is_last);
        int unsigned  len;
        int           i;
        bit           hit;
        t_scan_result res;
        len = active_length();
        for (i = WINDOW_DEPTH - 1; i > 0; i--)
            window_bytes[i] = window_bytes[i-1];
        window_bytes[0] = data;
        bytes_seen = bytes_seen + 1'b1;
        if (!region_done) begin
            hit = (len == 0) || (bytes_seen >= len);
            for (i = 0; i < len; i++) begin
                if (pattern_byte(i) != wild_value && pattern_byte(i) != window_bytes[len-1-i])
                    hit = 1'b0;
            end
            if (hit) begin
                res.found  = 1'b1;
                res.offset = (len == 0) ? '0 : wbps_pkg::t_offset'(bytes_seen - len);
                results_due.push_back(res);
                region_done = 1'b1;
            end else if (is_last) begin
                res.found  = 1'b0;
                res.offset = '0;
                results_due.push_back(res);
            end
        end
        if (is_last)
            clear_window();
    endfunction

    task automatic write_reg(wbps_pkg::t_cfg_idx idx, logic [wbps_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx) inside
            wbps_pkg::REG_PAT_WORD_0, wbps_pkg::REG_PAT_WORD_1,
            wbps_pkg::REG_PAT_WORD_2, wbps_pkg::REG_PAT_WORD_3:
                pat_words[idx[wbps_pkg::PAT_WORD_IDX_W-1:0]] = value;
            wbps_pkg::REG_WILDCARD: wild_value = value[wbps_pkg::DATA_W-1:0];
            wbps_pkg::REG_PAT_LEN:  pat_len = value[wbps_pkg::LEN_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [wbps_pkg::CFG_DATA_W-1:0] w0, w1, w2, w3,
                             input wbps_pkg::t_byte wild,
                             input logic [wbps_pkg::LEN_CFG_W-1:0] len);
        write_reg(wbps_pkg::REG_PAT_WORD_0, w0);
        write_reg(wbps_pkg::REG_PAT_WORD_1, w1);
        write_reg(wbps_pkg::REG_PAT_WORD_2, w2);
        write_reg(wbps_pkg::REG_PAT_WORD_3, w3);
        write_reg(wbps_pkg::REG_WILDCARD,
                  {{(wbps_pkg::CFG_DATA_W-wbps_pkg::DATA_W){1'b0}}, wild});
        write_reg(wbps_pkg::REG_PAT_LEN,
                  {{(wbps_pkg::CFG_DATA_W-wbps_pkg::LEN_CFG_W){1'b0}}, len});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE_6, {$urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE_7, {$urandom, $urandom});
        repeat (4) @(posedge i_clk);
    endtask

    // A pattern of random bytes with some of them turned into the wildcard value.
    task automatic random_config(bit short_pattern);
        logic [wbps_pkg::CFG_DATA_W-1:0] w [wbps_pkg::NUM_PAT_WORDS];
        wbps_pkg::t_byte                 wild;
        logic [wbps_pkg::LEN_CFG_W-1:0]  len;
        int                              k;
        int                              b;
        int                              sel;
        case ($urandom_range(0, 3))
            0:       wild = 8'h00;
            1:       wild = 8'hFF;
            default: wild = wbps_pkg::t_byte'($urandom_range(0, 255));
        endcase
        for (k = 0; k < wbps_pkg::NUM_PAT_WORDS; k++) begin
            w[k] = {$urandom, $urandom};
            for (b = 0; b < wbps_pkg::BYTES_PER_WORD; b++)
                if ($urandom_range(0, 3) == 0)
                    w[k][b*wbps_pkg::DATA_W +: wbps_pkg::DATA_W] = wild;
        end
        sel = $urandom_range(0, 19);
        if (short_pattern)
            len = wbps_pkg::LEN_CFG_W'($urandom_range(1, 2));
        else if (sel == 0)
            len = '0;
        else if (sel <= 2)
            len = wbps_pkg::LEN_CFG_W'(32);
        else if (sel == 3)
            len = wbps_pkg::LEN_CFG_W'($urandom_range(33, 63));
        else if (sel <= 5)
            len = wbps_pkg::LEN_CFG_W'($urandom_range(9, 31));
        else
            len = wbps_pkg::LEN_CFG_W'($urandom_range(1, 6));
        configure(w[0], w[1], w[2], w[3], wild, len);
    endtask

    task automatic push_byte(wbps_pkg::t_byte data, logic is_last);
        byte_queue.push_back('{data: data, is_last: is_last});
        bytes_queued++;
    endtask

    // Filler leans on pattern bytes so that partial matches are common; a planted
    // copy of the pattern gives a full match at a random start.
    task automatic push_region(int unsigned n, bit plant, bit close);
        wbps_pkg::t_byte region_bytes [$];
        int unsigned     len;
        int unsigned     start;
        int unsigned     k;
        len = active_length();
        for (k = 0; k < n; k++)
            region_bytes.push_back(($urandom_range(0, 1) == 0 && len != 0) ?
                pattern_byte($urandom_range(0, len - 1)) :
                wbps_pkg::t_byte'($urandom_range(0, 255)));
        if (plant && len != 0 && n >= len) begin
            start = $urandom_range(0, n - len);
            for (k = 0; k < len; k++)
                if (pattern_byte(k) != wild_value)
                    region_bytes[start+k] = pattern_byte(k);
        end
        for (k = 0; k < n; k++)
            push_byte(region_bytes[k], close && (k == n - 1));
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (byte_queue.size() != 0 || byte_ch.valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Byte sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : byte_driver
        t_region_byte next_byte;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready)
                scan_byte(byte_ch.data_byte, byte_ch.last_byte);
            if (!byte_ch.valid || byte_ch.ready) begin
                if (gap_left != 0) begin
                    byte_ch.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (byte_queue.size() != 0) begin
                    next_byte = byte_queue.pop_front();
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= next_byte.data;
                    byte_ch.last_byte <= next_byte.is_last;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: checks each word, then picks its ready from the current stall mode.
    always @(posedge i_clk) begin : result_monitor
        t_scan_result expected;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result word with none expected: found %0b offset %0d",
                             $time, result_ch.found, result_ch.match_offset);
                    error_count++;
                end else begin
                    expected = results_due.pop_front();
                    if (result_ch.found !== expected.found) begin
                        $display("%0t: found mismatch: expected %0b, got %0b",
                                 $time, expected.found, result_ch.found);
                        error_count++;
                    end
                    if (result_ch.match_offset !== expected.offset) begin
                        $display("%0t: match_offset mismatch: expected %0d, got %0d",
                                 $time, expected.offset, result_ch.match_offset);
                        error_count++;
                    end
                end
            end
            rx_tick <= rx_tick + 1'b1;
            if (long_hold_req) begin
                long_hold_req   <= 1'b0;
                hold_left       <= LONG_HOLD;
                result_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left       <= hold_left - 1;
                result_ch.ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      <= t_rx_mode'($urandom_range(0, 3));
                    rx_mode_left <= $urandom_range(8, 120);
                end else begin
                    rx_mode_left <= rx_mode_left - 1;
                end
                case (rx_mode)
                    RX_OPEN:          result_ch.ready <= 1'b1;
                    RX_COIN:          result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_THREE_OF_FOUR: result_ch.ready <= (rx_tick != 2'b11);
                    RX_SPARSE:        result_ch.ready <= ($urandom_range(0, 5) == 0);
                    default:          result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("wildcard_byte_pattern_search_core_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int          phase;
        int          phase_start;
        int          phase_target;
        int unsigned n;
        bit          hold_phase;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = wbps_pkg::REG_PAT_WORD_0;
        i_cfg_data        = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready   = 1'b0;
        long_hold_req     = 1'b0;
        for (int k = 0; k < wbps_pkg::NUM_PAT_WORDS; k++)
            pat_words[k] = '0;
        wild_value = '0;
        pat_len    = wbps_pkg::PAT_LEN_RESET;
        clear_window();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset pattern is a single wildcard byte, so every byte matches at once.
        @(negedge i_clk);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_drained();

        // "A?C": a match ending on the last byte, a match followed by ignored bytes
        // that include another match, and a region shorter than the pattern.
        configure(64'h0000_0000_0043_FF41, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 8'hFF, 6'd3);
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, {$urandom, $urandom});
        @(negedge i_clk);
        push_byte(8'h00, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h43, 1'b1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h43, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h43, 1'b1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        wait_drained();

        // An empty pattern matches at offset 0 on the first byte.
        write_reg(wbps_pkg::REG_PAT_LEN, '0);
        @(negedge i_clk);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        wait_drained();

        // A length of 63 saturates to the window depth, so three bytes cannot match.
        configure('0, '0, '0, '0, 8'h00, 6'd63);
        @(negedge i_clk);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h5A, 1'b1);
        wait_drained();

        // Zero as the wildcard value with an all-ones pattern byte.
        configure(64'h0000_0000_0000_00FF, '0, '0, '0, 8'h00, 6'd1);
        @(negedge i_clk);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);

        phase = 0;
        while (bytes_queued < TARGET_BYTES) begin
            wait_drained();
            // In the hold phases short regions with short patterns owe many results,
            // so the core fills up while the receiver is held off.
            hold_phase = (phase == 2) || (phase == 8);
            random_config(hold_phase);
            @(negedge i_clk);
            if (hold_phase)
                long_hold_req = 1'b1;
            phase_start  = bytes_queued;
            phase_target = $urandom_range(80, 180);
            while (bytes_queued - phase_start < phase_target) begin
                if (hold_phase) begin
                    n = $urandom_range(1, 3);
                end else begin
                    case ($urandom_range(0, 7))
                        0:       n = $urandom_range(1, 4);
                        1:       n = $urandom_range(40, 100);
                        default: n = $urandom_range(1, active_length() + 16);
                    endcase
                end
                push_region(n, $urandom_range(0, 2) != 0, 1'b1);
            end
            // Sometimes leave a region open so the next configuration lands mid-region.
            if ($urandom_range(0, 3) == 0)
                push_region($urandom_range(1, 10), 1'b1, 1'b0);
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && results_due.size() == 0)
            $display("wildcard_byte_pattern_search_core_tb: PASS");
        else
            $display("wildcard_byte_pattern_search_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/wbps_pkg.sv
src/wbps_in_if.sv
src/wbps_out_if.sv
src/wildcard_byte_pattern_search_core.sv
tb/sv/wildcard_byte_pattern_search_core_tb.sv
